>>> design/fmcb_pkg.sv
// Package for the bilinear flow matching cost block.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package fmcb_pkg;
    localparam int MAX_COLS_DEF       = 256;
    localparam int MAX_ROWS_DEF       = 256;
    localparam int DISP_FRAC_BITS_DEF = 4;

    typedef enum logic [1:0] {
        REQ_WR_FIRST  = 2'd0,
        REQ_WR_SECOND = 2'd1,
        REQ_QUERY     = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_NUM_COLS = 2'd0,
        CFG_NUM_ROWS = 2'd1,
        CFG_WINDOW   = 2'd2
    } cfg_idx_t;
endpackage

>>> design/fmcb_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// No dependencies.
`timescale 1ns / 1ps
module fmcb_sqrt #(
    parameter int IN_W  = 48,
    parameter int OUT_W = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_val,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_root
);
    // one result bit per stage, radicand shifted in two bits a stage
    logic [OUT_W:0]    vld_reg;
    logic [IN_W-1:0]   rad_reg  [OUT_W+1];
    logic [OUT_W+1:0]  rem_reg  [OUT_W+1];
    logic [OUT_W-1:0]  root_reg [OUT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[OUT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= in_val;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        logic [OUT_W+1:0] cur;
        logic [OUT_W+1:0] trial;
        always_comb
        begin
            cur   = {rem_reg[s][OUT_W-1:0], rad_reg[s][IN_W-1 -: 2]};
            trial = {root_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            rad_reg[s+1] <= rad_reg[s] << 2;
            if (cur >= trial)
            begin
                rem_reg[s+1]  <= cur - trial;
                root_reg[s+1] <= {root_reg[s][OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1]  <= cur;
                root_reg[s+1] <= {root_reg[s][OUT_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[OUT_W];
    assign out_root  = root_reg[OUT_W];
endmodule

>>> design/flow_matching_cost_bilinear.sv
// Top level of the bilinear flow matching cost block.
// Uses fmcb_pkg and fmcb_sqrt; holds both image memories.
//
// Usage: the in channel carries writes of first or second image pixels and
// cost queries. A write gives no word out. A query reads the second image
// four times and the first image once from memories with one read port,
// so it is held on the input through phases 0 to 4 and taken in phase 4;
// items behind it wait. Its cost word then passes the capture registers,
// stages A to F (blend, difference, square, sum), the square root pipeline
// and the result FIFO, then is valid on the out channel. Throughput: one
// write a cycle while no query is held. The config port is always ready.
// Reset restores num_cols and num_rows to 256 and window_width to 31 and
// empties the pipeline; image contents are undefined until written.
// A stalled out channel holds its word; results collect in a 32-entry FIFO
// and a new query waits before its first read once 31 words are stored or
// in flight.
`timescale 1ns / 1ps
module flow_matching_cost_bilinear #(
    parameter int MAX_COLS       = fmcb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS       = fmcb_pkg::MAX_ROWS_DEF,
    parameter int DISP_FRAC_BITS = fmcb_pkg::DISP_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [7:0]  chan0,
    input  logic [7:0]  chan1,
    input  logic [7:0]  chan2,
    input  logic [9:0]  disp_x,
    input  logic [9:0]  disp_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] match_cost
);
    import fmcb_pkg::*;

    localparam int FB    = DISP_FRAC_BITS;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int PW    = 14 + FB;          // signed position, 2^-(FB+1) units
    localparam int CHW   = 8 + 2 * FB;       // interpolated channel width
    localparam int DW    = CHW + 1;
    localparam int SQW   = 2 * CHW + 2;      // sum of three squares
    localparam int UP    = (FB <= 4) ? (16 - 4 * FB) : 0;
    localparam int DN    = (FB > 4) ? (2 * FB - 8) : 0;
    localparam int RADW  = SQW + UP + ((SQW + UP) % 2);
    localparam int ROOTW = RADW / 2;
    localparam int QD    = 32;
    localparam int QAW   = 5;

    logic [8:0] ncols_reg, nrows_reg;
    logic [6:0] win_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncols_reg <= 9'd256;
            nrows_reg <= 9'd256;
            win_reg   <= 7'd31;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUM_COLS: ncols_reg <= cfg_data;
                CFG_NUM_ROWS: nrows_reg <= cfg_data;
                CFG_WINDOW:   win_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [23:0] img1_mem [DEPTH];
    logic [23:0] img2_mem [DEPTH];

    // effective sizes minus one
    logic [12:0] cmax, rmax;
    always_comb
    begin
        if (ncols_reg == 9'd0)
            cmax = '0;
        else if (13'(ncols_reg) > 13'(MAX_COLS))
            cmax = 13'(MAX_COLS - 1);
        else
            cmax = 13'(ncols_reg) - 13'd1;
        if (nrows_reg == 9'd0)
            rmax = '0;
        else if (13'(nrows_reg) > 13'(MAX_ROWS))
            rmax = 13'(MAX_ROWS - 1);
        else
            rmax = 13'(nrows_reg) - 13'd1;
    end

    // credit tracking for the result FIFO
    logic [QAW:0] cnt_reg, cnt_next;
    logic [2:0]   ph_reg, ph_next;
    logic         busy;
    logic         room;
    logic         acc;
    req_t         rq;

    assign rq   = req_t'(req_type);
    assign room = cnt_reg < (QAW+1)'(QD - 1);
    assign busy = ph_reg != 3'd0;
    assign in_stall = (rq == REQ_QUERY) ? (ph_reg != 3'd4) : busy;
    assign acc  = in_valid && !in_stall;

    // sample coordinates
    logic signed [PW-1:0] pxs, pys;
    logic [CW-1:0] xl, xh, c0c;
    logic [RW-1:0] yl, yh, c0r;

    function automatic logic [12:0] clampv(input logic signed [PW-1:0] v,
                                           input logic [12:0] hi);
        logic signed [PW:0] hv;
        begin
            hv = (PW+1)'(signed'({1'b0, hi}));
            if (v < 0)
                clampv = '0;
            else if ((PW+1)'(v) > hv)
                clampv = hi;
            else
                clampv = 13'(v);
        end
    endfunction

    always_comb
    begin
        logic [6:0] w;
        logic signed [PW-1:0] half;
        logic signed [PW-1:0] fx, cx, fy, cy;
        w    = (win_reg == 7'd0) ? 7'd1 : win_reg;
        half = PW'(signed'({1'b0, w - 7'd1})) <<< FB;
        pxs  = (PW'(signed'({1'b0, col})) <<< (FB + 1))
             + (PW'(signed'({1'b0, disp_x})) <<< 1) - half;
        pys  = (PW'(signed'({1'b0, row})) <<< (FB + 1))
             + (PW'(signed'({1'b0, disp_y})) <<< 1) - half;
        fx = pxs >>> (FB + 1);
        cx = (pxs + PW'((1 << (FB + 1)) - 1)) >>> (FB + 1);
        fy = pys >>> (FB + 1);
        cy = (pys + PW'((1 << (FB + 1)) - 1)) >>> (FB + 1);
        xl  = CW'(clampv(fx, cmax));
        xh  = CW'(clampv(cx, cmax));
        yl  = RW'(clampv(fy, rmax));
        yh  = RW'(clampv(cy, rmax));
        c0c = CW'(clampv(PW'(signed'({1'b0, col})), cmax));
        c0r = RW'(clampv(PW'(signed'({1'b0, row})), rmax));
    end

    // phase 0..4 of a query: second image reads p1..p4, then first image
    logic          inq;
    assign inq = in_valid && rq == REQ_QUERY && (busy || room);

    always_comb
    begin
        ph_next = ph_reg;
        if (inq)
            ph_next = (ph_reg == 3'd4) ? 3'd0 : ph_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= '0;
        else
            ph_reg <= ph_next;
    end

    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr2;
    logic [AW-1:0] raddr1;
    logic          wok;
    assign waddr  = {RW'(row), CW'(col)};
    assign wok    = (13'(col) < 13'(MAX_COLS)) && (13'(row) < 13'(MAX_ROWS));
    assign raddr1 = {c0r, c0c};
    always_comb
    begin
        case (ph_reg)
            3'd0:    raddr2 = {yl, xl};
            3'd1:    raddr2 = {yh, xl};
            3'd2:    raddr2 = {yl, xh};
            default: raddr2 = {yh, xh};
        endcase
    end

    logic [23:0] rd1_reg, rd2_reg;
    always_ff @(posedge clk)
    begin
        if (acc && rq == REQ_WR_FIRST && wok)
            img1_mem[waddr] <= {chan2, chan1, chan0};
        rd1_reg <= img1_mem[raddr1];
    end
    always_ff @(posedge clk)
    begin
        if (acc && rq == REQ_WR_SECOND && wok)
            img2_mem[waddr] <= {chan2, chan1, chan0};
        rd2_reg <= img2_mem[raddr2];
    end

    // capture sequence
    logic [2:0]  cph_reg;
    logic        cv_reg;
    logic [23:0] q1_reg, q2_reg, q3_reg;
    logic [FB-1:0] fxm, fym;
    assign fxm = disp_x[FB-1:0];
    assign fym = disp_y[FB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg  <= 1'b0;
            cph_reg <= '0;
        end
        else
        begin
            cv_reg  <= inq;
            cph_reg <= ph_reg;
        end
    end

    logic [FB:0] axn, ayn;
    always_comb
    begin
        axn = (fxm == '0) ? '0 : (FB+1)'(1 << FB) - (FB+1)'(fxm);
        ayn = (fym == '0) ? '0 : (FB+1)'(1 << FB) - (FB+1)'(fym);
    end

    logic [FB:0] ax_reg, ay_reg, axs_reg, ays_reg;
    always_ff @(posedge clk)
    begin
        if (inq && ph_reg == 3'd0)
        begin
            axs_reg <= axn;
            ays_reg <= ayn;
        end
        if (cv_reg)
        begin
            case (cph_reg)
                3'd0:    q1_reg <= rd2_reg;
                3'd1:    q2_reg <= rd2_reg;
                3'd2:    q3_reg <= rd2_reg;
                default: ;
            endcase
        end
    end

    // stage A: all five pixels present
    logic        a_v_reg;
    logic [23:0] a0_reg, a1_reg, a2_reg, a3_reg, a4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= cv_reg && cph_reg == 3'd4;
    end
    logic [23:0] q4_reg;
    always_ff @(posedge clk)
    begin
        if (cv_reg && cph_reg == 3'd3)
            q4_reg <= rd2_reg;
        a0_reg <= rd1_reg;
        a1_reg <= q1_reg;
        a2_reg <= q2_reg;
        a3_reg <= q3_reg;
        a4_reg <= q4_reg;
        ax_reg <= axs_reg;
        ay_reg <= ays_reg;
    end

    // stage B: vertical blend; stage C: horizontal blend; D: diff; E: square;
    // F: sum
    logic             b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg;
    logic [8+FB:0]    w1_reg [3], w2_reg [3];
    logic [7:0]       b0_reg [3];
    logic [FB:0]      bax_reg;
    logic [CHW:0]     c1_reg [3];
    logic [7:0]       c0_reg [3];
    logic [CHW:0]     ad_reg [3];
    logic [SQW-1:0]   sq_reg [3];
    logic [SQW-1:0]   sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_ch
        logic [FB:0] uy, ux;
        assign uy = (FB+1)'(1 << FB) - ay_reg;
        assign ux = (FB+1)'(1 << FB) - bax_reg;
        always_ff @(posedge clk)
        begin
            w1_reg[k] <= (9+FB)'(ay_reg * a1_reg[8*k +: 8]) + (9+FB)'(uy * a2_reg[8*k +: 8]);
            w2_reg[k] <= (9+FB)'(ay_reg * a3_reg[8*k +: 8]) + (9+FB)'(uy * a4_reg[8*k +: 8]);
            b0_reg[k] <= a0_reg[8*k +: 8];
            c1_reg[k] <= (CHW+1)'(bax_reg * w1_reg[k]) + (CHW+1)'(ux * w2_reg[k]);
            c0_reg[k] <= b0_reg[k];
            if ((DW)'({c0_reg[k], {(2*FB){1'b0}}}) >= c1_reg[k])
                ad_reg[k] <= (DW)'({c0_reg[k], {(2*FB){1'b0}}}) - c1_reg[k];
            else
                ad_reg[k] <= c1_reg[k] - (DW)'({c0_reg[k], {(2*FB){1'b0}}});
            sq_reg[k] <= SQW'(ad_reg[k] * ad_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        bax_reg <= ax_reg;
        sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    logic              s_v;
    logic [ROOTW-1:0]  s_root;
    fmcb_sqrt #(.IN_W(RADW), .OUT_W(ROOTW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_v_reg),
        .in_val    (RADW'(sum_reg) << UP),
        .out_valid (s_v),
        .out_root  (s_root)
    );

    // result FIFO; cnt_reg also counts words still in flight
    logic [16:0]   fifo_mem [QD];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic          pop;
    logic [ROOTW-1:0] sh;
    assign sh  = s_root >> DN;
    assign out_valid  = wp_reg != rp_reg;
    assign match_cost = fifo_mem[rp_reg];
    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (s_v)
            fifo_mem[wp_reg] <= 17'(sh);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (inq && ph_reg == 3'd0)
            cnt_next = cnt_next + (QAW+1)'(1);
        if (pop)
            cnt_next = cnt_next - (QAW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (s_v)
                wp_reg <= wp_reg + QAW'(1);
            if (pop)
                rp_reg <= rp_reg + QAW'(1);
        end
    end
endmodule
